[sv/hfcs_pkg.sv]
// ----------------------------------------------------------------------------
// hfcs_pkg
// Shared types and constants for the hand frame clock sync and button unit.
// ----------------------------------------------------------------------------
package hfcs_pkg;

	localparam int US_W      = 53;  // sensor stamp width, microseconds
	localparam int RECV_W    = 63;  // receive time width, nanoseconds
	localparam int TIME_W    = 64;  // mapped time / offset width
	localparam int STR_W     = 16;  // Q0.16 strength
	localparam int CFG_IDX_W = 2;

	localparam int CREEP_SHIFT = 10; // offset creeps by 1/1024 of the gap

	localparam logic [CFG_IDX_W-1:0] REG_PRESS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 2'd1;

	localparam logic [STR_W-1:0] PRESS_RST   = 16'd55706; // 0.85
	localparam logic [STR_W-1:0] RELEASE_RST = 16'd36045; // 0.55

	typedef struct packed {
		logic             present;
		logic [STR_W-1:0] pinch;
		logic [STR_W-1:0] grab;
	} hand_in_t;

	typedef struct packed {
		logic tracked;
		logic select;
		logic menu;
	} hand_out_t;

	typedef struct packed {
		logic [STR_W-1:0] press_thr;
		logic [STR_W-1:0] release_thr;
	} thr_t;

endpackage

[sv/hfcs_hand.sv]
// ----------------------------------------------------------------------------
// hfcs_hand
// Select/menu button latches with press/release hysteresis for one hand.
// ----------------------------------------------------------------------------
module hfcs_hand import hfcs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  hand_in_t  hand,
	input  thr_t      thr,
	output hand_out_t res
);

	logic sel_q;
	logic menu_q;
	logic sel_d;
	logic menu_d;

	// press test wins when thresholds are crossed
	function automatic logic hyst(logic cur, logic [STR_W-1:0] s, thr_t t);
		logic r;
		if (s > t.press_thr) begin
			r = 1'b1;
		end else if (s < t.release_thr) begin
			r = 1'b0;
		end else begin
			r = cur;
		end
		return r;
	endfunction

	always_comb begin
		if (hand.present) begin
			sel_d  = hyst(sel_q, hand.pinch, thr);
			menu_d = hyst(menu_q, hand.grab, thr);
		end else begin
			sel_d  = 1'b0;
			menu_d = 1'b0;
		end
		res.tracked = hand.present;
		res.select  = sel_d;
		res.menu    = menu_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q  <= 1'b0;
			menu_q <= 1'b0;
		end else if (step) begin
			sel_q  <= sel_d;
			menu_q <= menu_d;
		end
	end

endmodule

[sv/hand_frame_clock_sync_and_buttons_unit.sv]
// ----------------------------------------------------------------------------
// hand_frame_clock_sync_and_buttons_unit
// Maps tracking frame stamps into the local clock through a latency-floor
// offset and turns pinch/grab strength into select/menu buttons per hand.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake              Word
// -------   ---  ---------------------  --------------------------------------
// in        in   in_valid / in_ready    stamps, presence, pinch, grab x2
// out       out  out_valid / out_ready  mapped time, tracked/select/menu x2
// cfg       in   cfg_valid / cfg_ready  cfg_index, cfg_data (thresholds)
//
// One word per cycle while out_ready is high, one result per word; a word
// passes s1 input, s2 stamp x1000, s3 instant offset, s4 offset/latch
// update (the recurrence closes there) and s5 output, then out_valid rises.
// Stalls: a stage advances when the one below is empty or moving, so out_ready
// low backs up to in_ready. Reset clears valids, offset, known flag, latches
// and sets thresholds to their defaults. cfg is always ready; thresholds apply at the s4 update.
//
module hand_frame_clock_sync_and_buttons_unit import hfcs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// input frames
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [US_W-1:0]      sensor_time_us,
	input  logic [RECV_W-1:0]    receive_time_ns,
	input  logic                 left_present,
	input  logic [STR_W-1:0]     left_pinch,
	input  logic [STR_W-1:0]     left_grab,
	input  logic                 right_present,
	input  logic [STR_W-1:0]     right_pinch,
	input  logic [STR_W-1:0]     right_grab,
	// results
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [TIME_W-1:0] mapped_time_ns,
	output logic                 left_tracked,
	output logic                 left_select,
	output logic                 left_menu,
	output logic                 right_tracked,
	output logic                 right_select,
	output logic                 right_menu,
	// configuration
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [STR_W-1:0]     cfg_data
);

	// ---- configuration registers ----
	thr_t thr_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.press_thr   <= PRESS_RST;
			thr_q.release_thr <= RELEASE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PRESS:   thr_q.press_thr   <= cfg_data;
				REG_RELEASE: thr_q.release_thr <= cfg_data;
				default:     ;  // unmapped index, write dropped
			endcase
		end
	end

	// ---- pipeline flow control ----
	// stage advance enables, computed from the output back
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	assign en_s5    = !v_s5 || out_ready;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	// ---- s1: input register ----
	logic [US_W-1:0]   us_s1;
	logic [RECV_W-1:0] recv_s1;
	hand_in_t          lh_s1, rh_s1;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			us_s1   <= sensor_time_us;
			recv_s1 <= receive_time_ns;
			lh_s1   <= '{present: left_present, pinch: left_pinch, grab: left_grab};
			rh_s1   <= '{present: right_present, pinch: right_pinch, grab: right_grab};
		end
	end

	// ---- s2: stamp to nanoseconds ----
	// x1000 = x1024 - x16 - x8; a 53-bit stamp stays below 2^63
	logic [TIME_W-1:0] us_ext;
	logic [TIME_W-1:0] ns_d;
	logic [TIME_W-1:0] ns_s2;
	logic [RECV_W-1:0] recv_s2;
	logic              nostamp_s2;
	hand_in_t          lh_s2, rh_s2;

	assign us_ext = TIME_W'(us_s1);
	assign ns_d   = (us_ext << 10) - (us_ext << 4) - (us_ext << 3);

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			ns_s2      <= ns_d;
			recv_s2    <= recv_s1;
			nostamp_s2 <= (us_s1 == '0);
			lh_s2      <= lh_s1;
			rh_s2      <= rh_s1;
		end
	end

	// ---- s3: instant offset = receive - stamp ----
	logic [TIME_W-1:0] ns_s3;
	logic [TIME_W-1:0] inst_s3;
	logic [RECV_W-1:0] recv_s3;
	logic              nostamp_s3;
	hand_in_t          lh_s3, rh_s3;

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			ns_s3      <= ns_s2;
			inst_s3    <= TIME_W'(recv_s2) - ns_s2;
			recv_s3    <= recv_s2;
			nostamp_s3 <= nostamp_s2;
			lh_s3      <= lh_s2;
			rh_s3      <= rh_s2;
		end
	end

	// ---- s3 -> s4: offset and button latch update ----
	// latch state moves exactly once per frame, when the frame leaves s3; the offset moves then only for a stamped frame
	logic              step_s3;
	logic [TIME_W-1:0] off_q;
	logic              known_q;
	logic [TIME_W-1:0] gap;
	logic              take_min;
	logic [TIME_W-1:0] off_d;
	hand_out_t         lres_d, rres_d;

	assign step_s3 = v_s3 && en_s4;

	// gap is exact and non-negative whenever the creep branch is taken
	assign gap      = inst_s3 - off_q;
	assign take_min = !known_q || ($signed(inst_s3) < $signed(off_q));
	assign off_d    = take_min ? inst_s3 : off_q + (gap >> CREEP_SHIFT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q   <= '0;
			known_q <= 1'b0;
		end else if (step_s3 && !nostamp_s3) begin
			off_q   <= off_d;
			known_q <= 1'b1;
		end
	end

	hfcs_hand u_left (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step_s3),
		.hand   (lh_s3),
		.thr    (thr_q),
		.res    (lres_d)
	);

	hfcs_hand u_right (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step_s3),
		.hand   (rh_s3),
		.thr    (thr_q),
		.res    (rres_d)
	);

	// ---- s4: updated offset carried with the frame ----
	logic [TIME_W-1:0] ns_s4;
	logic [TIME_W-1:0] off_s4;
	logic [RECV_W-1:0] recv_s4;
	logic              nostamp_s4;
	hand_out_t         lres_s4, rres_s4;

	always_ff @(posedge clk) begin
		if (step_s3) begin
			ns_s4      <= ns_s3;
			off_s4     <= off_d;
			recv_s4    <= recv_s3;
			nostamp_s4 <= nostamp_s3;
			lres_s4    <= lres_d;
			rres_s4    <= rres_d;
		end
	end

	// ---- s5: output register ----
	logic [TIME_W-1:0] mapped_s5;
	hand_out_t         lres_s5, rres_s5;

	always_ff @(posedge clk) begin
		if (en_s5 && v_s4) begin
			mapped_s5 <= nostamp_s4 ? TIME_W'(recv_s4) : ns_s4 + off_s4;
			lres_s5   <= lres_s4;
			rres_s5   <= rres_s4;
		end
	end

	assign out_valid      = v_s5;
	assign mapped_time_ns = $signed(mapped_s5);
	assign left_tracked   = lres_s5.tracked;
	assign left_select    = lres_s5.select;
	assign left_menu      = lres_s5.menu;
	assign right_tracked  = rres_s5.tracked;
	assign right_select   = rres_s5.select;
	assign right_menu     = rres_s5.menu;

	// ---- assertions ----
	// once an offset is held it is never forgotten
	a_known_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		known_q |=> known_q)
		else $error("offset-known flag dropped");

	// the offset never rises above the instant value that moved it
	a_off_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(step_s3 && !nostamp_s3) |=> ($signed(off_q) <= $signed($past(inst_s3))))
		else $error("offset above instant value");

	// an empty output slot never holds off the input
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// an absent hand carries no buttons
	a_absent_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && (!lres_s4.tracked || !rres_s4.tracked)) |->
		((lres_s4.tracked || (!lres_s4.select && !lres_s4.menu)) &&
		 (rres_s4.tracked || (!rres_s4.select && !rres_s4.menu))))
		else $error("buttons set on absent hand");

endmodule
